// File: rtl/hevc_codec_string_parser_defines.svh
// Assertion macros for the codec string parser checker.
`ifndef HEVC_CODEC_STRING_PARSER_DEFINES_SVH
`define HEVC_CODEC_STRING_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HCSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HCSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hcsp_pkg.sv
// Shared types and constants for the codec string parser.
package hcsp_pkg;

  localparam int CONSTRAINT_BYTES_DEF = 6;
  localparam int MAX_CONSTRAINT_BYTES = 6;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;

  // parser phases
  localparam logic [3:0] PH_DOT0   = 4'd0;
  localparam logic [3:0] PH_SPACE  = 4'd1;
  localparam logic [3:0] PH_PROF   = 4'd2;
  localparam logic [3:0] PH_COMPAT = 4'd3;
  localparam logic [3:0] PH_TIER   = 4'd4;
  localparam logic [3:0] PH_LEVEL  = 4'd5;
  localparam logic [3:0] PH_CONS   = 4'd6;

  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_H   = 8'h48;
  localparam logic [7:0] CHAR_L   = 8'h4C;

  localparam logic [6:0] PROFILE_MAX = 7'd31;
  localparam logic [9:0] LEVEL_MAX   = 10'd255;

  // decoded character classes
  typedef struct packed {
    logic       is_dec;
    logic       is_hex;
    logic [3:0] digit;
    logic       is_dot;
    logic       is_space;
    logic [1:0] space_code;
    logic       is_tier;
    logic       tier_h;
  } hcsp_char_t;

  // verdict for one string
  typedef struct packed {
    logic        ok;
    logic [1:0]  space;
    logic        tier_h;
    logic [4:0]  profile;
    logic [31:0] compat;
    logic [7:0]  level;
    logic [47:0] cons;
    logic [2:0]  count;
  } hcsp_verdict_t;

endpackage

// File: rtl/hcsp_char_class.sv
// Character classifier: digits, hex digits, dot and the letters of the tail.
module hcsp_char_class (
  input  logic [7:0]          char_code,
  output hcsp_pkg::hcsp_char_t cls
);
  import hcsp_pkg::*;

  logic dec, hex_lo, hex_up;

  always_comb begin
    dec    = (char_code >= 8'h30) && (char_code <= 8'h39);
    hex_lo = (char_code >= 8'h61) && (char_code <= 8'h66);
    hex_up = (char_code >= 8'h41) && (char_code <= 8'h46);
    cls.is_dec     = dec;
    cls.is_hex     = dec || hex_lo || hex_up;
    // letters a-f / A-F have 1..6 in the low nibble
    cls.digit      = dec ? char_code[3:0] : (char_code[3:0] + 4'd9);
    cls.is_dot     = (char_code == CHAR_DOT);
    cls.is_space   = (char_code >= 8'h41) && (char_code <= 8'h43);
    cls.space_code = char_code[1:0];
    cls.is_tier    = (char_code == CHAR_L) || (char_code == CHAR_H);
    cls.tier_h     = (char_code == CHAR_H);
  end

endmodule

// File: rtl/hcsp_parser.sv
// Parser state, per-character update and end-of-string verdict.
module hcsp_parser #(
  parameter int CONSTRAINT_BYTES = hcsp_pkg::CONSTRAINT_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic                    last,
  input  hcsp_pkg::hcsp_char_t    ch,
  output hcsp_pkg::hcsp_verdict_t verdict
);
  import hcsp_pkg::*;

  localparam logic [2:0] GROUP_LIMIT = 3'(CONSTRAINT_BYTES);

  logic [3:0]  phase_r,   phase_nxt;
  logic [3:0]  run_r,     run_nxt;
  logic        failed_r,  failed_nxt;
  logic [1:0]  space_r,   space_nxt;
  logic [6:0]  prof_r,    prof_nxt;
  logic [31:0] compat_r,  compat_nxt;
  logic        tier_r,    tier_nxt;
  logic [9:0]  level_r,   level_nxt;
  logic [47:0] cons_r,    cons_nxt;
  logic [7:0]  gbyte_r,   gbyte_nxt;
  logic [2:0]  gidx_r,    gidx_nxt;

  logic        end_ok;

  // byte placed at its lane, group 0 in the top byte
  function automatic logic [47:0] lane(input logic [7:0] b, input logic [2:0] idx);
    logic [47:0] res;
    res = '0;
    for (int k = 0; k < MAX_CONSTRAINT_BYTES; k++) begin
      if (idx == 3'(k)) res[47 - 8*k -: 8] = b;
    end
    return res;
  endfunction

  always_comb begin
    phase_nxt  = phase_r;
    run_nxt    = run_r;
    failed_nxt = failed_r;
    space_nxt  = space_r;
    prof_nxt   = prof_r;
    compat_nxt = compat_r;
    tier_nxt   = tier_r;
    level_nxt  = level_r;
    cons_nxt   = cons_r;
    gbyte_nxt  = gbyte_r;
    gidx_nxt   = gidx_r;

    if (fire && !failed_r) begin
      if (phase_r == PH_SPACE && ch.is_space) begin
        space_nxt = ch.space_code;
        phase_nxt = PH_PROF;
      end else if (phase_r == PH_SPACE || phase_r == PH_PROF) begin
        // no space letter: this is already the first profile character
        phase_nxt = PH_PROF;
        if (ch.is_dec) begin
          if (run_r >= 4'd2) failed_nxt = 1'b1;
          else begin
            run_nxt  = run_r + 4'd1;
            prof_nxt = 7'({prof_r, 3'b000} + {prof_r, 1'b0} + {3'b000, ch.digit});
          end
        end else if (ch.is_dot && run_r != 4'd0 && prof_r <= PROFILE_MAX) begin
          phase_nxt = PH_COMPAT;
          run_nxt   = '0;
        end else failed_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_DOT0: begin
            if (ch.is_dot) begin
              phase_nxt = PH_SPACE;
              run_nxt   = '0;
            end else failed_nxt = 1'b1;
          end
          PH_COMPAT: begin
            if (ch.is_hex) begin
              if (run_r >= 4'd8) failed_nxt = 1'b1;
              else begin
                run_nxt    = run_r + 4'd1;
                compat_nxt = {compat_r[27:0], ch.digit};
              end
            end else if (ch.is_dot && run_r != 4'd0) begin
              phase_nxt = PH_TIER;
              run_nxt   = '0;
            end else failed_nxt = 1'b1;
          end
          PH_TIER: begin
            if (ch.is_tier) begin
              tier_nxt  = ch.tier_h;
              phase_nxt = PH_LEVEL;
              run_nxt   = '0;
            end else failed_nxt = 1'b1;
          end
          PH_LEVEL: begin
            if (ch.is_dec) begin
              if (run_r >= 4'd3) failed_nxt = 1'b1;
              else begin
                run_nxt   = run_r + 4'd1;
                level_nxt = 10'({level_r, 3'b000} + {level_r, 1'b0} + {6'd0, ch.digit});
              end
            end else if (ch.is_dot && run_r != 4'd0 && level_r <= LEVEL_MAX) begin
              phase_nxt = PH_CONS;
              run_nxt   = '0;
              gidx_nxt  = '0;
              gbyte_nxt = '0;
            end else failed_nxt = 1'b1;
          end
          PH_CONS: begin
            if (ch.is_hex) begin
              if (run_r >= 4'd2) failed_nxt = 1'b1;
              else begin
                run_nxt   = run_r + 4'd1;
                gbyte_nxt = {gbyte_r[3:0], ch.digit};
              end
            end else if (ch.is_dot && run_r != 4'd0) begin
              cons_nxt = cons_r | lane(gbyte_r, gidx_r);
              gidx_nxt = gidx_r + 3'd1;
              if ((gidx_r + 3'd1) >= GROUP_LIMIT) failed_nxt = 1'b1;
              else begin
                run_nxt   = '0;
                gbyte_nxt = '0;
              end
            end else failed_nxt = 1'b1;
          end
          default: failed_nxt = 1'b1;
        endcase
      end
    end
  end

  // verdict seen from the state after this character
  always_comb begin
    end_ok = !failed_nxt && run_nxt != 4'd0 &&
             ((phase_nxt == PH_LEVEL && level_nxt <= LEVEL_MAX) || phase_nxt == PH_CONS);
    verdict = '0;
    if (end_ok) begin
      verdict.ok      = 1'b1;
      verdict.space   = space_nxt;
      verdict.tier_h  = tier_nxt;
      verdict.profile = prof_nxt[4:0];
      verdict.compat  = compat_nxt;
      verdict.level   = level_nxt[7:0];
      if (phase_nxt == PH_CONS) begin
        verdict.cons  = cons_nxt | lane(gbyte_nxt, gidx_nxt);
        verdict.count = gidx_nxt + 3'd1;
      end else begin
        verdict.cons  = cons_nxt;
      end
    end
  end

  // the end of a string returns everything to its reset value
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last)) begin
      phase_r  <= PH_DOT0;
      run_r    <= '0;
      failed_r <= 1'b0;
      space_r  <= '0;
      prof_r   <= '0;
      compat_r <= '0;
      tier_r   <= 1'b0;
      level_r  <= '0;
      cons_r   <= '0;
      gbyte_r  <= '0;
      gidx_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      run_r    <= run_nxt;
      failed_r <= failed_nxt;
      space_r  <= space_nxt;
      prof_r   <= prof_nxt;
      compat_r <= compat_nxt;
      tier_r   <= tier_nxt;
      level_r  <= level_nxt;
      cons_r   <= cons_nxt;
      gbyte_r  <= gbyte_nxt;
      gidx_r   <= gidx_nxt;
    end
  end

endmodule

// File: rtl/hevc_codec_string_parser.sv
// Top level of the H.265 codec string tail parser with its result register.
// Throughput: one character per cycle while in_tready is high; the parser state updates in the cycle of the transfer.
// The verdict is registered and appears on out_* in the cycle after the transfer of the last character.
// The result register is the only stall point: input stalls only while a verdict waits.
// Reset (rst_n low, synchronous): parser back to "expect first dot", result register empty.
module hevc_codec_string_parser #(
  parameter int CONSTRAINT_BYTES = hcsp_pkg::CONSTRAINT_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel, one character per transfer
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hcsp_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_code
  input  logic                             in_tlast,   // is_last
  // result channel, one verdict per string
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hcsp_pkg::OUT_TDATA_W-1:0] out_tdata,  // [1:0] space_id, [2] tier_high,
                                                       // [7:3] profile_number,
                                                       // [39:8] compat_flags,
                                                       // [47:40] level_number,
                                                       // [95:48] constraint_bytes,
                                                       // [98:96] constraint_count, rest zero
  output logic                             out_tuser   // accepted
);
  import hcsp_pkg::*;

  hcsp_char_t    ch;
  hcsp_verdict_t verdict;
  logic          in_fire;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tuser_r;

  // a fresh transfer may land whenever the result register is free or being emptied
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  hcsp_char_class u_class (
    .char_code (in_tdata[7:0]),
    .cls       (ch)
  );

  hcsp_parser #(
    .CONSTRAINT_BYTES (CONSTRAINT_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .last    (in_tlast),
    .ch      (ch),
    .verdict (verdict)
  );

  // result register: loaded on the last character, cleared once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire && in_tlast) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      out_tdata_r <= {5'd0, verdict.count, verdict.cons, verdict.level, verdict.compat,
                      verdict.profile, verdict.tier_h, verdict.space};
      out_tuser_r <= verdict.ok;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: rtl/hcsp_checker.sv
// Port-level checker for the codec string parser, bound to the top level.
`include "hevc_codec_string_parser_defines.svh"

module hcsp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hcsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import hcsp_pkg::*;

  logic in_xfer, out_stall;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  `HCSP_ASSERT_NEXT(a_last_gives_verdict, in_xfer && in_tlast, out_tvalid, "no verdict after last character")

  `HCSP_ASSERT_NEXT(a_no_spurious_verdict, in_xfer && !in_tlast && !out_stall, !out_tvalid, "verdict without last character")

  `HCSP_ASSERT_NOW(a_reject_is_zero, out_tvalid && !out_tuser, out_tdata == '0, "rejected verdict carries fields")

  `HCSP_ASSERT_NEXT(a_stall_holds, out_stall, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled verdict changed")

endmodule

bind hevc_codec_string_parser hcsp_checker u_hcsp_checker (.*);
